/* design/wfhc_pkg.sv */
// ----------------------------------------------------------------------------
// wfhc_pkg
// Shared types and codes of the word frequency hash counter: item layouts,
// command and result codes, hash seed.
// ----------------------------------------------------------------------------
package wfhc_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned LEN_W   = 7;

  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_COUNTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] text_byte;
    logic [SLOT_W-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic               is_new;
    logic [LEN_W-1:0]   word_length;
    logic [COUNT_W-1:0] total_words;
  } out_item_t;

endpackage

/* design/wfhc_if.sv */
// ----------------------------------------------------------------------------
// wfhc_in_if / wfhc_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface wfhc_in_if;
  logic               valid;
  logic               ready;
  wfhc_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface wfhc_out_if;
  logic                valid;
  logic                ready;
  wfhc_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

/* design/wfhc_mod_unit.sv */
// ----------------------------------------------------------------------------
// wfhc_mod_unit
// Remainder of a 32-bit value by a constant through reciprocal
// multiplication: quotient estimate, back-multiply and subtract, one
// correction step, each registered in turn. done pulses with the remainder.
// ----------------------------------------------------------------------------
module wfhc_mod_unit #(
  parameter int unsigned DIVISOR = 211,
  parameter int unsigned REM_W   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dividend_i,
  output logic             done_o,
  output logic [REM_W-1:0] rem_o
);

  // floor(2^32 / DIVISOR): the estimate is low by at most one
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(DIVISOR));
  localparam logic [31:0] DIV_C = 32'(DIVISOR);

  logic [2:0]       stage_q, stage_d;
  logic             done_q, done_d;
  logic [31:0]      dvd_q, dvd_d;
  logic [31:0]      quo_q, quo_d;
  logic [31:0]      est_q, est_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [63:0]      prod;

  always_comb begin
    prod    = {32'd0, dvd_q} * {31'd0, RECIP};
    stage_d = {stage_q[1:0], start_i};
    done_d  = stage_q[2];
    dvd_d   = start_i ? dividend_i : dvd_q;
    quo_d   = stage_q[0] ? prod[63:32] : quo_q;
    // true remainder plus at most one divisor
    est_d   = stage_q[1] ? (dvd_q - quo_q * DIV_C) : est_q;
    rem_d   = rem_q;
    if (stage_q[2]) begin
      rem_d = (est_q >= DIV_C) ? REM_W'(est_q - DIV_C) : REM_W'(est_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= stage_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    est_q <= est_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* design/word_frequency_hash_counter_core.sv */
// ----------------------------------------------------------------------------
// word_frequency_hash_counter_core
// Counts word frequencies in a byte stream with a djb2 hash and chained
// buckets held in synchronous memories.
// ----------------------------------------------------------------------------
// Input channel in_i: text bytes, end-of-text flush, slot read commands.
// Output channel out_o: at most one result item per input item.
// A word byte is hashed and buffered as it is taken. A word end (separator,
// flush, or a word reaching MAX_WORD bytes) runs the hash mod BUCKETS, one
// bucket head read, then per chain entry a length check and, on equal
// length, a byte-by-byte compare; an insert copies the word bytes.
// For a word end, the walk of its chain over the entry and key memories
// and the copy of a new word decide when its result is ready.
// A read of a used slot gives its result after the entry memory read in
// S_RDW, a read of an unused slot in the cycle after the item is taken.
// After reset the bucket heads are cleared at one entry a cycle; no item
// is accepted until all BUCKETS heads are cleared.
// A finished result sits in an output register; while it is not taken the
// block accepts no further item.
// ----------------------------------------------------------------------------
module word_frequency_hash_counter_core #(
  parameter int unsigned ENTRIES  = 1024,
  parameter int unsigned BUCKETS  = 211,
  parameter int unsigned MAX_WORD = 99
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  wfhc_in_if.sink          in_i,
  wfhc_out_if.source       out_o
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned LINK_W = $clog2(ENTRIES + 1);
  localparam int unsigned BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_WORD + 1);
  localparam int unsigned POS_W  = $clog2(MAX_WORD);
  localparam int unsigned KEY_AW = IDX_W + POS_W;
  localparam logic [LINK_W-1:0] EMPTY = LINK_W'(ENTRIES);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_HEAD = 4'd3;
  localparam logic [3:0] S_ENT  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_INS  = 4'd6;
  localparam logic [3:0] S_CPY  = 4'd7;
  localparam logic [3:0] S_RDW  = 4'd8;

  // memories
  logic [7:0]        key_mem  [2**KEY_AW];
  logic [7:0]        wb_mem   [MAX_WORD];
  logic [FILL_W-1:0] len_mem  [ENTRIES];
  logic [31:0]       cnt_mem  [ENTRIES];
  logic [LINK_W-1:0] link_mem [ENTRIES];
  logic [LINK_W-1:0] head_mem [BUCKETS];

  logic [7:0]        key_rd, wb_rd;
  logic [FILL_W-1:0] ent_len_rd;
  logic [31:0]       ent_cnt_rd;
  logic [LINK_W-1:0] ent_link_rd, head_rd;

  logic              key_we, key_re, wb_we, wb_re, ent_we, ent_re, head_we;
  logic [KEY_AW-1:0] key_waddr, key_raddr;
  logic [7:0]        key_wdata, wb_wdata;
  logic [POS_W-1:0]  wb_waddr, wb_raddr;
  logic [IDX_W-1:0]  ent_waddr, ent_raddr;
  logic [FILL_W-1:0] ent_wlen;
  logic [31:0]       ent_wcnt;
  logic [LINK_W-1:0] ent_wlink, head_wdata;
  logic [BKT_W-1:0]  head_waddr, head_raddr;

  // control state
  logic [3:0]        state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [31:0]       hash_q, hash_d;
  logic [31:0]       words_q, words_d;
  logic [LINK_W-1:0] used_q, used_d;
  logic [BKT_W-1:0]  clr_q, clr_d;
  logic              out_valid_q, out_valid_d;

  // datapath registers
  logic [BKT_W-1:0]    bucket_q, bucket_d;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic [LINK_W-1:0]   link_q, link_d;
  logic [LINK_W-1:0]   head_q, head_d;
  logic [FILL_W-1:0]   pos_q, pos_d;
  logic [wfhc_pkg::SLOT_W-1:0] rslot_q, rslot_d;
  wfhc_pkg::out_item_t out_q, out_d;

  logic                mod_start, mod_done;
  logic [BKT_W-1:0]    mod_rem;
  logic                accept, separator, finish;
  logic [31:0]         byte_ext;
  logic [FILL_W-1:0]   fill_inc, pos_inc;
  logic [16:0]         rd_idx_ext, used_ext;
  logic [31:0]         cnt_sat;
  logic                res_push;
  wfhc_pkg::out_item_t res;
  wfhc_pkg::in_item_t  in_item;

  wfhc_mod_unit #(
    .DIVISOR (BUCKETS),
    .REM_W   (BKT_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (hash_d),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign in_item  = in_i.item;
  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept   = in_i.valid && in_i.ready;
  assign separator = (in_item.text_byte == 8'd0) || (in_item.text_byte == 8'd32) ||
                     (in_item.text_byte inside {[8'd9:8'd13]});
  assign byte_ext = {{24{in_item.text_byte[7]}}, in_item.text_byte};
  assign fill_inc = fill_q + FILL_W'(1);
  assign pos_inc  = pos_q + FILL_W'(1);
  assign rd_idx_ext = 17'(in_item.slot_index);
  assign used_ext   = 17'(used_q);
  assign cnt_sat  = (ent_cnt_rd == 32'hFFFF_FFFF) ? ent_cnt_rd : ent_cnt_rd + 32'd1;

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    hash_d   = hash_q;
    words_d  = words_q;
    used_d   = used_q;
    clr_d    = clr_q;
    bucket_d = bucket_q;
    cur_d    = cur_q;
    link_d   = link_q;
    head_d   = head_q;
    pos_d    = pos_q;
    rslot_d  = rslot_q;
    finish   = 1'b0;
    mod_start = 1'b0;

    key_we = 1'b0; key_waddr = {cur_q, pos_q[POS_W-1:0]}; key_wdata = wb_rd;
    key_re = 1'b0; key_raddr = {cur_q, pos_q[POS_W-1:0]};
    wb_we  = 1'b0; wb_waddr  = fill_q[POS_W-1:0]; wb_wdata = in_item.text_byte;
    wb_re  = 1'b0; wb_raddr  = pos_q[POS_W-1:0];
    ent_we = 1'b0; ent_waddr = cur_q; ent_wlen = ent_len_rd;
    ent_wcnt = cnt_sat; ent_wlink = link_q;
    ent_re = 1'b0; ent_raddr = cur_q;
    head_we = 1'b0; head_waddr = clr_q; head_wdata = EMPTY;
    head_raddr = mod_rem;

    res_push = 1'b0;
    res.result_kind = wfhc_pkg::KIND_COUNTED;
    res.slot        = wfhc_pkg::SLOT_W'(cur_q);
    res.count       = cnt_sat;
    res.is_new      = 1'b0;
    res.word_length = wfhc_pkg::LEN_W'(fill_q);
    res.total_words = words_q;

    case (state_q)
      S_CLR: begin
        head_we = 1'b1;
        clr_d   = clr_q + BKT_W'(1);
        if (clr_q == BKT_W'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_item.command)
            wfhc_pkg::CMD_BYTE: begin
              if (separator) begin
                finish = (fill_q != '0);
              end else begin
                hash_d = (hash_q << 5) + hash_q + byte_ext;
                wb_we  = 1'b1;
                fill_d = fill_inc;
                finish = (fill_inc >= FILL_W'(MAX_WORD));
              end
            end
            wfhc_pkg::CMD_FLUSH: begin
              finish = (fill_q != '0);
            end
            wfhc_pkg::CMD_READ: begin
              rslot_d = in_item.slot_index;
              if (rd_idx_ext < used_ext) begin
                ent_re    = 1'b1;
                ent_raddr = IDX_W'(in_item.slot_index);
                state_d   = S_RDW;
              end else begin
                res_push        = 1'b1;
                res.result_kind = wfhc_pkg::KIND_READ;
                res.slot        = in_item.slot_index;
                res.count       = '0;
                res.word_length = '0;
              end
            end
            default: ;
          endcase
          if (finish) begin
            mod_start = 1'b1;
            words_d   = (words_q == 32'hFFFF_FFFF) ? words_q : words_q + 32'd1;
            state_d   = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          bucket_d = mod_rem;
          state_d  = S_HEAD;
        end
      end
      S_HEAD: begin
        head_d = head_rd;
        if (head_rd == EMPTY) begin
          state_d = S_INS;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = IDX_W'(head_rd);
          cur_d     = IDX_W'(head_rd);
          state_d   = S_ENT;
        end
      end
      S_ENT: begin
        link_d = ent_link_rd;
        if (ent_len_rd == fill_q) begin
          pos_d     = '0;
          key_re    = 1'b1;
          key_raddr = {cur_q, POS_W'(0)};
          wb_re     = 1'b1;
          wb_raddr  = '0;
          state_d   = S_CMP;
        end else if (ent_link_rd == EMPTY) begin
          state_d = S_INS;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = IDX_W'(ent_link_rd);
          cur_d     = IDX_W'(ent_link_rd);
        end
      end
      S_CMP: begin
        if (key_rd != wb_rd) begin
          if (link_q == EMPTY) begin
            state_d = S_INS;
          end else begin
            ent_re    = 1'b1;
            ent_raddr = IDX_W'(link_q);
            cur_d     = IDX_W'(link_q);
            state_d   = S_ENT;
          end
        end else if (pos_inc == fill_q) begin
          // whole word matches: bump the count in place
          ent_we   = 1'b1;
          res_push = 1'b1;
          fill_d   = '0;
          hash_d   = wfhc_pkg::HASH_SEED;
          state_d  = S_IDLE;
        end else begin
          pos_d     = pos_inc;
          key_re    = 1'b1;
          key_raddr = {cur_q, pos_inc[POS_W-1:0]};
          wb_re     = 1'b1;
          wb_raddr  = pos_inc[POS_W-1:0];
        end
      end
      S_INS: begin
        if (used_q == EMPTY) begin
          res_push        = 1'b1;
          res.result_kind = wfhc_pkg::KIND_DROPPED;
          res.slot        = '0;
          res.count       = '0;
          fill_d          = '0;
          hash_d          = wfhc_pkg::HASH_SEED;
          state_d         = S_IDLE;
        end else begin
          pos_d    = '0;
          wb_re    = 1'b1;
          wb_raddr = '0;
          state_d  = S_CPY;
        end
      end
      S_CPY: begin
        key_we    = 1'b1;
        key_waddr = {IDX_W'(used_q), pos_q[POS_W-1:0]};
        if (pos_inc == fill_q) begin
          ent_we     = 1'b1;
          ent_waddr  = IDX_W'(used_q);
          ent_wlen   = fill_q;
          ent_wcnt   = 32'd1;
          ent_wlink  = head_q;
          head_we    = 1'b1;
          head_waddr = bucket_q;
          head_wdata = used_q;
          used_d     = used_q + LINK_W'(1);
          res_push   = 1'b1;
          res.slot   = wfhc_pkg::SLOT_W'(used_q);
          res.count  = 32'd1;
          res.is_new = 1'b1;
          fill_d     = '0;
          hash_d     = wfhc_pkg::HASH_SEED;
          state_d    = S_IDLE;
        end else begin
          pos_d    = pos_inc;
          wb_re    = 1'b1;
          wb_raddr = pos_inc[POS_W-1:0];
        end
      end
      S_RDW: begin
        res_push        = 1'b1;
        res.result_kind = wfhc_pkg::KIND_READ;
        res.slot        = rslot_q;
        res.count       = ent_cnt_rd;
        res.word_length = wfhc_pkg::LEN_W'(ent_len_rd);
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    if (res_push) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      fill_q      <= '0;
      hash_q      <= wfhc_pkg::HASH_SEED;
      words_q     <= '0;
      used_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      hash_q      <= hash_d;
      words_q     <= words_d;
      used_q      <= used_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bucket_q <= bucket_d;
    cur_q    <= cur_d;
    link_q   <= link_d;
    head_q   <= head_d;
    pos_q    <= pos_d;
    rslot_q  <= rslot_d;
    out_q    <= out_d;
  end

  // synchronous memories with registered read data
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (key_re) begin
      key_rd <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_we) begin
      wb_mem[wb_waddr] <= wb_wdata;
    end
    if (wb_re) begin
      wb_rd <= wb_mem[wb_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      len_mem[ent_waddr]  <= ent_wlen;
      cnt_mem[ent_waddr]  <= ent_wcnt;
      link_mem[ent_waddr] <= ent_wlink;
    end
    if (ent_re) begin
      ent_len_rd  <= len_mem[ent_raddr];
      ent_cnt_rd  <= cnt_mem[ent_raddr];
      ent_link_rd <= link_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd <= head_mem[head_raddr];
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

endmodule

/* dv/word_frequency_hash_counter_core_test.sv */
// ----------------------------------------------------------------------------
// word_frequency_hash_counter_core_test
// Self-checking bench: drives text bytes, flushes and slot reads through the
// input channel, predicts each result with an in-bench hash table model or
// a directed row and compares each result item field by field. Covers
// separators, long words, high bytes, repeated words and unused slot reads.
// ----------------------------------------------------------------------------
module word_frequency_hash_counter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES  = 1024;
  localparam int unsigned BUCKETS  = 211;
  localparam int unsigned MAX_WORD = 99;
  localparam logic [wfhc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wfhc_in_if  in_ch ();
  wfhc_out_if out_ch ();

  word_frequency_hash_counter_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // table model state
  logic [7:0]  key_bytes [ENTRIES][MAX_WORD];
  logic [6:0]  key_len [ENTRIES];
  logic [31:0] freq [ENTRIES];
  int unsigned chain_next [ENTRIES];
  int unsigned head [BUCKETS];
  int unsigned slots_used;
  logic [7:0]  pend [MAX_WORD];
  int unsigned pend_len;
  logic [31:0] djb2;
  logic [31:0] word_total;

  wfhc_pkg::out_item_t result_q[$];
  int unsigned mismatches = 0;
  int unsigned n_counted = 0, n_reads = 0, n_dropped = 0, n_sent = 0;
  int unsigned send_idle_pct = 0, stall_pct = 0, hold_cycles = 0;
  logic        in_fire, out_fire;

  function automatic bit is_space(logic [7:0] b);
    return b == 8'd0 || b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic wfhc_pkg::out_item_t close_word();
    wfhc_pkg::out_item_t r;
    int unsigned bkt, cur, steps, s;
    bit          hit;
    bkt = djb2 % BUCKETS;
    cur = head[bkt];
    steps = 0;
    hit = 0;
    if (word_total != 32'hFFFF_FFFF) word_total++;
    while (cur < ENTRIES && steps < ENTRIES && !hit) begin
      if (key_len[cur] == pend_len) begin
        hit = 1;
        for (int i = 0; i < pend_len; i++)
          if (key_bytes[cur][i] != pend[i]) hit = 0;
      end
      if (!hit) begin
        cur = chain_next[cur];
        steps++;
      end
    end
    if (hit) begin
      if (freq[cur] != 32'hFFFF_FFFF) freq[cur]++;
      r = '{wfhc_pkg::KIND_COUNTED, cur[9:0], freq[cur], 1'b0, pend_len[6:0],
            word_total};
    end else if (slots_used >= ENTRIES) begin
      r = '{wfhc_pkg::KIND_DROPPED, 10'd0, 32'd0, 1'b0, pend_len[6:0], word_total};
    end else begin
      s = slots_used;
      slots_used++;
      for (int i = 0; i < pend_len; i++) key_bytes[s][i] = pend[i];
      key_len[s] = pend_len[6:0];
      freq[s] = 32'd1;
      chain_next[s] = head[bkt];
      head[bkt] = s;
      r = '{wfhc_pkg::KIND_COUNTED, s[9:0], 32'd1, 1'b1, pend_len[6:0], word_total};
    end
    pend_len = 0;
    djb2 = wfhc_pkg::HASH_SEED;
    return r;
  endfunction

  // advances the model by one item; has_res tells whether a result follows
  function automatic void count_words(input wfhc_pkg::in_item_t it, output bit has_res,
                                      output wfhc_pkg::out_item_t r);
    has_res = 0;
    r = '0;
    case (it.command)
      wfhc_pkg::CMD_BYTE: begin
        if (is_space(it.text_byte)) begin
          if (pend_len > 0) begin
            r = close_word();
            has_res = 1;
          end
        end else begin
          djb2 = djb2 * 32'd33 + {{24{it.text_byte[7]}}, it.text_byte};
          if (pend_len < MAX_WORD) begin
            pend[pend_len] = it.text_byte;
            pend_len++;
          end
          if (pend_len >= MAX_WORD) begin
            r = close_word();
            has_res = 1;
          end
        end
      end
      wfhc_pkg::CMD_FLUSH: begin
        if (pend_len > 0) begin
          r = close_word();
          has_res = 1;
        end
      end
      wfhc_pkg::CMD_READ: begin
        has_res = 1;
        if (it.slot_index < slots_used)
          r = '{wfhc_pkg::KIND_READ, it.slot_index, freq[it.slot_index], 1'b0,
                key_len[it.slot_index], word_total};
        else
          r = '{wfhc_pkg::KIND_READ, it.slot_index, 32'd0, 1'b0, 7'd0, word_total};
      end
      default: ;
    endcase
  endfunction

  task automatic send(input wfhc_pkg::in_item_t it, input bit known = 0,
                      input wfhc_pkg::out_item_t want = '0);
    bit                  has_res;
    wfhc_pkg::out_item_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    count_words(it, has_res, r);
    if (has_res) result_q.push_back(known ? want : r);
    if (it.command != CMD_UNUSED) n_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send('{wfhc_pkg::CMD_BYTE, b, 10'($urandom)});
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (is_space(b));
    return b;
  endfunction

  function automatic logic [7:0] any_space();
    logic [7:0] sp [7] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd0};
    return sp[$urandom_range(6)];
  endfunction

  // result side: check, then choose ready for the next cycle
  always @(posedge clk_i or negedge rst_ni) begin
    wfhc_pkg::out_item_t want, got;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.item;
        if (got.result_kind == wfhc_pkg::KIND_COUNTED) n_counted++;
        else if (got.result_kind == wfhc_pkg::KIND_READ) n_reads++;
        else n_dropped++;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", got);
        end else begin
          want = result_q.pop_front();
          if (got.result_kind !== want.result_kind || got.slot !== want.slot ||
              got.count !== want.count || got.is_new !== want.is_new ||
              got.word_length !== want.word_length ||
              got.total_words !== want.total_words) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk_i) begin
    int unsigned idle;
    in_fire  = in_ch.valid && in_ch.ready;
    out_fire = out_ch.valid && out_ch.ready;
    if (in_fire || out_fire) idle = 0;
    else idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle);
      $display("word_frequency_hash_counter_core verification failed");
      $finish;
    end
  end

  typedef struct {
    logic [wfhc_pkg::CMD_W-1:0] cmd;
    logic [7:0]                 b;
    logic [9:0]                 idx;
    int unsigned                reps;
    bit                         known;
    wfhc_pkg::out_item_t        want;
  } row_t;

  row_t rows [] = '{
    '{wfhc_pkg::CMD_READ, 8'h00, 10'd0, 1, 1,
      '{wfhc_pkg::KIND_READ, 10'd0, 32'd0, 1'b0, 7'd0, 32'd0}},
    '{wfhc_pkg::CMD_READ, 8'hFF, 10'd1023, 1, 1,
      '{wfhc_pkg::KIND_READ, 10'd1023, 32'd0, 1'b0, 7'd0, 32'd0}},
    '{wfhc_pkg::CMD_FLUSH, 8'h00, 10'd0, 1, 0, '0},
    '{CMD_UNUSED, 8'hFF, 10'd1023, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, 8'd32, 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, 8'd0, 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, "a", 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, 8'd32, 10'd0, 1, 1,
      '{wfhc_pkg::KIND_COUNTED, 10'd0, 32'd1, 1'b1, 7'd1, 32'd1}},
    '{wfhc_pkg::CMD_BYTE, "a", 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, 8'd9, 10'd0, 1, 1,
      '{wfhc_pkg::KIND_COUNTED, 10'd0, 32'd2, 1'b0, 7'd1, 32'd2}},
    '{wfhc_pkg::CMD_BYTE, 8'hFF, 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, 8'h80, 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, 8'd10, 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, "b", 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_FLUSH, 8'h00, 10'd0, 1, 0, '0},
    // 99 bytes close the word on their own, the 100th starts a new one
    '{wfhc_pkg::CMD_BYTE, "x", 10'd0, 100, 0, '0},
    '{wfhc_pkg::CMD_BYTE, 8'd13, 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, 8'd11, 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, "q", 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, 8'd12, 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, "q", 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_BYTE, 8'd0, 10'd0, 1, 0, '0},
    '{wfhc_pkg::CMD_READ, 8'h00, 10'd0, 1, 1,
      '{wfhc_pkg::KIND_READ, 10'd0, 32'd2, 1'b0, 7'd1, 32'd8}},
    '{wfhc_pkg::CMD_READ, 8'h00, 10'd1, 1, 0, '0},
    '{wfhc_pkg::CMD_READ, 8'h00, 10'd3, 1, 0, '0}
  };

  logic [7:0]  vocab [40][$];
  int unsigned vlen, pick;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.item  = '0;
    for (int i = 0; i < BUCKETS; i++) head[i] = ENTRIES;
    slots_used = 0;
    pend_len = 0;
    djb2 = wfhc_pkg::HASH_SEED;
    word_total = 0;
    for (int v = 0; v < 40; v++) begin
      vlen = $urandom_range(1, 8);
      repeat (vlen) vocab[v].push_back(word_byte());
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i])
      repeat (rows[i].reps)
        send('{rows[i].cmd, rows[i].b, rows[i].idx}, rows[i].known, rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      if (ph == 0) hold_cycles = 400;  // output stays full, input must back up
      while (n_sent < 25 + (ph + 1) * RANDOM_ITEMS / 4) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          vlen = $urandom_range(39);
          for (int j = 0; j < vocab[vlen].size(); j++) send_byte(vocab[vlen][j]);
          send_byte(any_space());
        end else if (pick < 65) begin
          repeat ($urandom_range(1, 12)) send_byte(word_byte());
          send_byte(any_space());
        end else if (pick < 69) begin
          repeat ($urandom_range(95, 110)) send_byte(word_byte());
          send_byte(any_space());
        end else if (pick < 80) begin
          if ($urandom_range(1) && slots_used > 0)
            send('{wfhc_pkg::CMD_READ, 8'($urandom),
                   10'($urandom_range(slots_used - 1))});
          else
            send('{wfhc_pkg::CMD_READ, 8'($urandom), 10'($urandom)});
        end else if (pick < 85) begin
          send('{wfhc_pkg::CMD_FLUSH, 8'($urandom), 10'($urandom)});
        end else if (pick < 91) begin
          send_byte(8'($urandom));
        end else if (pick < 94) begin
          send('{CMD_UNUSED, 8'($urandom), 10'($urandom)});
        end else begin
          send_byte(any_space());
        end
      end
      if (ph == 0) begin
        in_ch.valid <= 1'b0;
        wait (result_q.size() == 0);
        @(posedge clk_i);
      end
    end

    in_ch.valid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d input items: %0d words counted, %0d dropped,",
             n_sent, n_counted, n_dropped);
    $display("%0d slot reads, %0d table entries in use", n_reads, slots_used);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("word_frequency_hash_counter_core verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, result_q.size());
      $display("word_frequency_hash_counter_core verification failed");
    end
    $finish;
  end

endmodule

/* word_frequency_hash_counter_core.f */
design/wfhc_pkg.sv
design/wfhc_if.sv
design/wfhc_mod_unit.sv
design/word_frequency_hash_counter_core.sv
dv/word_frequency_hash_counter_core_test.sv
